// ----- hdl/cpd_pkg.sv -----
// Shared types and constants of the COBS packet deframer.
`default_nettype none

package cpd_pkg;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_REPLY  = 2'd2;

    // Reply bytes: ack is 0,2,1 and nack is 0,1,1.
    localparam logic [7:0] REPLY_HEAD     = 8'd0;
    localparam logic [7:0] REPLY_ACK_MID  = 8'd2;
    localparam logic [7:0] REPLY_NACK_MID = 8'd1;
    localparam logic [7:0] REPLY_TAIL     = 8'd1;

    // COBS code byte of a full block, which carries no implied zero.
    localparam logic [7:0] CODE_FULL = 8'hFF;

    // Depth of the command queue between front and back.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    // One command from the front: a decoded byte or the close of a frame.
    typedef struct packed {
        logic       frame_end;
        logic       nack;
        logic       ok;
        logic [7:0] value;
        logic [7:0] length;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/cpd_rx_if.sv -----
// Handshake channel that carries received bytes into the deframer.
`default_nettype none

interface cpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/cpd_res_if.sv -----
// Handshake channel that carries result items out of the deframer.
`default_nettype none

interface cpd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       packet_ok;
    logic [7:0] decoded_length;
    logic       last;

    modport source (output valid, output kind, output value, output packet_ok,
                    output decoded_length, output last, input ready);
    modport sink (input valid, input kind, input value, input packet_ok,
                  input decoded_length, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/cobs_packet_deframer_core.sv -----
// Top level of the COBS packet deframer.
// Received bytes enter on rx and are taken one per cycle while the four-entry
// command queue has room. A zero byte delimits frames; the bytes between are
// COBS-decoded as they arrive. A data result passes through the command queue
// and then the back end's output register, which holds it until res.ready. A
// delimiter that closes a frame gives four results: a status with packet_ok and
// decoded_length, then the ack reply 0,2,1. A frame longer than MAX_RAW_LENGTH
// raw bytes gives a bad status, the nack reply 0,1,1, and the receiver waits
// for the next delimiter. The result sequencer delivers one result per cycle
// while the consumer holds res.ready high; the sustained rate is set by that
// sequencer. Data items of a frame whose status is bad should be discarded by
// the consumer.
`default_nettype none

module cobs_packet_deframer_core #(
    parameter int MAX_RAW_LENGTH = 131
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cpd_rx_if.sink    rx,
    cpd_res_if.source res
);
    import cpd_pkg::*;

    cmd_t front_cmd;
    logic front_cmd_valid;
    logic front_cmd_ready;
    cmd_t queue_cmd;
    logic queue_cmd_valid;
    logic queue_cmd_pop;

    cpd_front #(
        .MAX_RAW_LENGTH (MAX_RAW_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cmd       (front_cmd),
        .cmd_valid (front_cmd_valid),
        .cmd_ready (front_cmd_ready)
    );

    cpd_cmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_cmd_valid),
        .in_cmd    (front_cmd),
        .in_ready  (front_cmd_ready),
        .out_valid (queue_cmd_valid),
        .out_cmd   (queue_cmd),
        .out_pop   (queue_cmd_pop)
    );

    cpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_cmd_valid),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_cmd_pop),
        .res       (res)
    );

endmodule

`default_nettype wire

// ----- hdl/cpd_front.sv -----
// Front end: sync machine and on-the-fly COBS decoding into commands.
`default_nettype none

module cpd_front #(
    parameter int MAX_RAW_LENGTH = 131
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cpd_rx_if.sink             rx,
    output cpd_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);
    import cpd_pkg::*;

    typedef enum logic [2:0] {
        MODE_UNSYNCED  = 3'b001,
        MODE_IN_ZEROS  = 3'b010,
        MODE_IN_PACKET = 3'b100
    } mode_t;

    localparam logic [7:0] MAX_RAW = 8'(MAX_RAW_LENGTH);

    mode_t      mode_reg, mode_next;
    logic [7:0] raw_count_reg, raw_count_next;
    logic [7:0] block_remaining_reg, block_remaining_next;
    logic       prev_code_full_reg, prev_code_full_next;
    logic [7:0] decoded_count_reg, decoded_count_next;
    logic       accept;
    logic       byte_zero;

    // A byte is taken whenever the queue has room for the command it may cause.
    assign rx.ready  = cmd_ready;
    assign accept    = rx.valid && cmd_ready;
    assign byte_zero = (rx.rx_byte == 8'd0);

    // Sync machine and block decoding.
    always_comb
    begin
        mode_next            = mode_reg;
        raw_count_next       = raw_count_reg;
        block_remaining_next = block_remaining_reg;
        prev_code_full_next  = prev_code_full_reg;
        decoded_count_next   = decoded_count_reg;
        cmd_valid            = 1'b0;
        cmd                  = '0;
        if (accept)
        begin
            case (mode_reg)
                MODE_IN_ZEROS:
                begin
                    if (!byte_zero)
                    begin
                        // The first nonzero byte is the frame's first code byte.
                        raw_count_next       = 8'd1;
                        decoded_count_next   = 8'd0;
                        block_remaining_next = rx.rx_byte - 8'd1;
                        prev_code_full_next  = (rx.rx_byte == CODE_FULL);
                        mode_next            = MODE_IN_PACKET;
                    end
                end
                MODE_IN_PACKET:
                begin
                    if (byte_zero)
                    begin
                        // Delimiter closes the frame and is acknowledged.
                        cmd_valid     = 1'b1;
                        cmd.frame_end = 1'b1;
                        cmd.ok        = (block_remaining_reg == 8'd0);
                        cmd.length    = decoded_count_reg;
                        mode_next     = MODE_IN_ZEROS;
                    end
                    else if (raw_count_reg >= MAX_RAW)
                    begin
                        // Frame too long: bad status, nack, and lose sync.
                        cmd_valid     = 1'b1;
                        cmd.frame_end = 1'b1;
                        cmd.nack      = 1'b1;
                        cmd.length    = decoded_count_reg;
                        mode_next     = MODE_UNSYNCED;
                    end
                    else
                    begin
                        raw_count_next = raw_count_reg + 8'd1;
                        if (block_remaining_reg != 8'd0)
                        begin
                            cmd_valid            = 1'b1;
                            cmd.value            = rx.rx_byte;
                            decoded_count_next   = decoded_count_reg + 8'd1;
                            block_remaining_next = block_remaining_reg - 8'd1;
                        end
                        else
                        begin
                            // New code byte; a short block before it implies a zero.
                            if (!prev_code_full_reg)
                            begin
                                cmd_valid          = 1'b1;
                                decoded_count_next = decoded_count_reg + 8'd1;
                            end
                            block_remaining_next = rx.rx_byte - 8'd1;
                            prev_code_full_next  = (rx.rx_byte == CODE_FULL);
                        end
                    end
                end
                default:
                begin
                    mode_next = byte_zero ? MODE_IN_ZEROS : MODE_UNSYNCED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_UNSYNCED;
            raw_count_reg       <= 8'd0;
            block_remaining_reg <= 8'd0;
            prev_code_full_reg  <= 1'b0;
            decoded_count_reg   <= 8'd0;
        end
        else
        begin
            mode_reg            <= mode_next;
            raw_count_reg       <= raw_count_next;
            block_remaining_reg <= block_remaining_next;
            prev_code_full_reg  <= prev_code_full_next;
            decoded_count_reg   <= decoded_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cpd_cmd_fifo.sv -----
// Short command queue between the front end and the result sequencer.
`default_nettype none

module cpd_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  cpd_pkg::cmd_t      in_cmd,
    output logic               in_ready,
    output logic               out_valid,
    output cpd_pkg::cmd_t      out_cmd,
    input  wire logic          out_pop
);
    import cpd_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // The fill count stays within the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue count beyond depth");

    // A pop on an empty queue never changes the count downwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) && !in_valid |=> count_reg == '0)
        else $error("command queue count moved while empty");

    // The count rises by one on every push that comes without a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue count missed a push");

endmodule

`default_nettype wire

// ----- hdl/cpd_back.sv -----
// Back end: expands commands into result items behind an output register.
`default_nettype none

module cpd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  cpd_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    cpd_res_if.source          res
);
    import cpd_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       packet_ok;
        logic [7:0] decoded_length;
        logic       last;
    } item_t;

    localparam logic [1:0] STEP_STATUS = 2'd0;
    localparam logic [1:0] STEP_FIRST  = 2'd1;
    localparam logic [1:0] STEP_MID    = 2'd2;
    localparam logic [1:0] STEP_LAST   = 2'd3;

    // Result item for a command at a given step of its expansion.
    function automatic item_t make_item(input cmd_t c, input logic [1:0] step);
        item_t it;
        it = '0;
        if (!c.frame_end)
        begin
            it.kind  = KIND_DATA;
            it.value = c.value;
            it.last  = 1'b1;
        end
        else
        begin
            case (step)
                STEP_STATUS:
                begin
                    it.kind           = KIND_STATUS;
                    it.packet_ok      = c.ok;
                    it.decoded_length = c.length;
                end
                STEP_FIRST:
                begin
                    it.kind  = KIND_REPLY;
                    it.value = REPLY_HEAD;
                end
                STEP_MID:
                begin
                    it.kind  = KIND_REPLY;
                    it.value = c.nack ? REPLY_NACK_MID : REPLY_ACK_MID;
                end
                default:
                begin
                    it.kind  = KIND_REPLY;
                    it.value = REPLY_TAIL;
                    it.last  = 1'b1;
                end
            endcase
        end
        return it;
    endfunction

    logic       out_valid_reg, out_valid_next;
    item_t      out_reg, out_next;
    logic       busy_reg, busy_next;
    logic [1:0] step_reg, step_next;
    cmd_t       cmd_reg, cmd_next;
    logic       out_free;

    assign out_free = !out_valid_reg || res.ready;

    // Sequencer: a frame close keeps the back busy for its reply bytes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        busy_next      = busy_reg;
        step_next      = step_reg;
        cmd_next       = cmd_reg;
        cmd_pop        = 1'b0;
        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = make_item(cmd_reg, step_reg);
                step_next      = step_reg + 2'd1;
                busy_next      = (step_reg != STEP_LAST);
            end
            else if (cmd_valid)
            begin
                cmd_pop        = 1'b1;
                out_valid_next = 1'b1;
                out_next       = make_item(cmd, STEP_STATUS);
                if (cmd.frame_end)
                begin
                    busy_next = 1'b1;
                    cmd_next  = cmd;
                    step_next = STEP_FIRST;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            step_reg      <= STEP_STATUS;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        cmd_reg <= cmd_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = out_reg.kind;
    assign res.value          = out_reg.value;
    assign res.packet_ok      = out_reg.packet_ok;
    assign res.decoded_length = out_reg.decoded_length;
    assign res.last           = out_reg.last;

    // A status item is always followed by its reply bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_STATUS) |-> !res.last && busy_reg)
        else $error("status item without pending reply");

    // Only a frame close keeps the sequencer busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cmd_reg.frame_end)
        else $error("sequencer busy on a data command");

    // The queue is not drained while reply bytes are still going out.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd_pop)
        else $error("command taken during a reply");

    // A data item is always the single result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_DATA) |-> res.last && !res.packet_ok)
        else $error("malformed data item");

endmodule

`default_nettype wire
